### src/cfm_pkg.sv
// ----------------------------------------------------------------------------
// cfm_pkg: shared types and constants of the CAN frame monitor
// Field widths, register indexes, reset values and the control state type.
// ----------------------------------------------------------------------------
package cfm_pkg;

  localparam int ID_W        = 29;
  localparam int STD_ID_W    = 11;
  localparam int LEN_W       = 4;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 32;
  localparam int FILL_OUT_W  = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 29;

  localparam logic [LEN_W-1:0]  MASK_MIN_LEN        = 4'd6;
  localparam logic [ID_W-1:0]   REPLY_ID_LOW_RESET  = 29'h7E8;
  localparam logic [ID_W-1:0]   REPLY_ID_HIGH_RESET = 29'h7EF;
  localparam logic [BYTE_W-1:0] ANSWER_MODE_RESET   = 8'h41;
  localparam logic [BYTE_W-1:0] ANSWER_PID_RESET    = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPLY_ID_LOW  = 2'd0,
    CFG_REPLY_ID_HIGH = 2'd1,
    CFG_ANSWER_MODE   = 2'd2,
    CFG_ANSWER_PID    = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic              is_remote;
    logic              is_extended;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  length_code;
    logic [BYTE_W-1:0] payload_b1;
    logic [BYTE_W-1:0] payload_b2;
    logic [BYTE_W-1:0] payload_b3;
    logic [BYTE_W-1:0] payload_b4;
    logic [BYTE_W-1:0] payload_b5;
    logic [BYTE_W-1:0] payload_b6;
  } frame_t;

  typedef struct packed {
    logic             was_counted;
    logic             was_reply;
    logic [CNT_W-1:0] total_frames;
    logic [CNT_W-1:0] total_replies;
    logic             mask_valid;
    logic [CNT_W-1:0] pid_mask;
  } stats_t;

  typedef struct packed {
    logic done;
    logic added;
  } lookup_status_t;

endpackage

### src/cfm_frame_if.sv
// ----------------------------------------------------------------------------
// cfm_frame_if: received frame channel
// Valid/ready channel carrying one received CAN frame per transaction.
// ----------------------------------------------------------------------------
interface cfm_frame_if
  import cfm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              is_remote;
  logic              is_extended;
  logic [ID_W-1:0]   frame_id;
  logic [LEN_W-1:0]  length_code;
  logic [BYTE_W-1:0] payload_b1;
  logic [BYTE_W-1:0] payload_b2;
  logic [BYTE_W-1:0] payload_b3;
  logic [BYTE_W-1:0] payload_b4;
  logic [BYTE_W-1:0] payload_b5;
  logic [BYTE_W-1:0] payload_b6;

  modport source (
    output valid, is_remote, is_extended, frame_id, length_code,
           payload_b1, payload_b2, payload_b3, payload_b4, payload_b5, payload_b6,
    input  ready
  );
  modport sink (
    input  valid, is_remote, is_extended, frame_id, length_code,
           payload_b1, payload_b2, payload_b3, payload_b4, payload_b5, payload_b6,
    output ready
  );
endinterface

### src/cfm_result_if.sv
// ----------------------------------------------------------------------------
// cfm_result_if: monitor result channel
// Valid/ready channel carrying one result per processed frame.
// ----------------------------------------------------------------------------
interface cfm_result_if
  import cfm_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  was_counted;
  logic                  was_reply;
  logic                  id_added;
  logic [CNT_W-1:0]      total_frames;
  logic [CNT_W-1:0]      total_replies;
  logic [FILL_OUT_W-1:0] distinct_ids;
  logic                  mask_valid;
  logic [CNT_W-1:0]      pid_mask;

  modport source (
    output valid, was_counted, was_reply, id_added, total_frames, total_replies,
           distinct_ids, mask_valid, pid_mask,
    input  ready
  );
  modport sink (
    input  valid, was_counted, was_reply, id_added, total_frames, total_replies,
           distinct_ids, mask_valid, pid_mask,
    output ready
  );
endinterface

### src/cfm_cfg_if.sv
// ----------------------------------------------------------------------------
// cfm_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface cfm_cfg_if
  import cfm_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/cfm_id_table.sv
// ----------------------------------------------------------------------------
// cfm_id_table: distinct standard identifier table
// Walks the stored identifiers one per cycle through a single comparator and
// appends the key when it is absent and a slot is free.
// ----------------------------------------------------------------------------
module cfm_id_table
  import cfm_pkg::*;
#(
  parameter int ID_SLOTS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [STD_ID_W-1:0]                  start_key,
  output lookup_status_t                       status,
  output logic [$clog2(ID_SLOTS+1)-1:0]        fill
);

  localparam int AW = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
  localparam int FW = $clog2(ID_SLOTS + 1);
  localparam logic [FW-1:0] SLOTS = FW'(ID_SLOTS);

  logic [STD_ID_W-1:0] mem [ID_SLOTS];
  logic [STD_ID_W-1:0] rd_data;
  logic [STD_ID_W-1:0] key;
  logic [FW-1:0]       scan_idx;
  logic                active;
  logic                pending;
  logic                done;
  logic                added;

  logic hit;
  logic issue;
  logic finish;
  logic wr_en;

  always_comb begin
    hit    = active && pending && (rd_data == key);
    issue  = active && !hit && (scan_idx < fill);
    finish = active && !hit && !issue;
    wr_en  = finish && (fill < SLOTS);
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[scan_idx[AW-1:0]];
    end
    if (wr_en) begin
      mem[fill[AW-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key <= start_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      pending  <= 1'b0;
      scan_idx <= '0;
      fill     <= '0;
      done     <= 1'b0;
      added    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active   <= 1'b1;
        pending  <= 1'b0;
        scan_idx <= '0;
        added    <= 1'b0;
      end else if (hit) begin
        active <= 1'b0;
        done   <= 1'b1;
        added  <= 1'b0;
      end else if (issue) begin
        scan_idx <= scan_idx + 1'b1;
        pending  <= 1'b1;
      end else if (finish) begin
        active <= 1'b0;
        done   <= 1'b1;
        added  <= wr_en;
        if (wr_en) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  assign status.done  = done;
  assign status.added = added;

endmodule

### src/cfm_stats.sv
// ----------------------------------------------------------------------------
// cfm_stats: frame and reply statistics
// Holds the configuration registers, the wrapping counters and the captured
// supported-PID mask, and offers their updated values for a committed frame.
// ----------------------------------------------------------------------------
module cfm_stats
  import cfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  commit,
  input  frame_t                frame,
  output stats_t                stats_next
);

  logic [ID_W-1:0]   reply_id_low;
  logic [ID_W-1:0]   reply_id_high;
  logic [BYTE_W-1:0] answer_mode;
  logic [BYTE_W-1:0] answer_pid;
  logic [CNT_W-1:0]  frame_total;
  logic [CNT_W-1:0]  reply_total;
  logic              mask_seen;
  logic [CNT_W-1:0]  mask_store;

  logic counted;
  logic reply;
  logic capture;

  always_comb begin
    counted = !frame.is_remote;
    reply   = counted && (frame.frame_id >= reply_id_low)
                      && (frame.frame_id <= reply_id_high);
    capture = reply && (frame.length_code >= MASK_MIN_LEN)
                    && (frame.payload_b1 == answer_mode)
                    && (frame.payload_b2 == answer_pid);
    stats_next.was_counted   = counted;
    stats_next.was_reply     = reply;
    stats_next.total_frames  = counted ? frame_total + 1'b1 : frame_total;
    stats_next.total_replies = reply ? reply_total + 1'b1 : reply_total;
    stats_next.mask_valid    = mask_seen || capture;
    stats_next.pid_mask      = capture ? {frame.payload_b3, frame.payload_b4,
                                          frame.payload_b5, frame.payload_b6}
                                       : mask_store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_id_low  <= REPLY_ID_LOW_RESET;
      reply_id_high <= REPLY_ID_HIGH_RESET;
      answer_mode   <= ANSWER_MODE_RESET;
      answer_pid    <= ANSWER_PID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_REPLY_ID_LOW:  reply_id_low  <= cfg_data;
        CFG_REPLY_ID_HIGH: reply_id_high <= cfg_data;
        CFG_ANSWER_MODE:   answer_mode   <= cfg_data[BYTE_W-1:0];
        CFG_ANSWER_PID:    answer_pid    <= cfg_data[BYTE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_total <= '0;
      reply_total <= '0;
      mask_seen   <= 1'b0;
      mask_store  <= '0;
    end else if (commit) begin
      frame_total <= stats_next.total_frames;
      reply_total <= stats_next.total_replies;
      mask_seen   <= stats_next.mask_valid;
      mask_store  <= stats_next.pid_mask;
    end
  end

endmodule

### src/can_frame_monitor_unit.sv
// ----------------------------------------------------------------------------
// can_frame_monitor_unit: received CAN frame monitor
// Counts frames and diagnostic replies, keeps a table of distinct standard
// identifiers and captures the supported-PID mask from matching replies.
//
//   Channel  Role    Payload
//   frame    sink    remote/extended flags, identifier, length, bytes 1..6
//   result   source  flags, totals, distinct ID count, mask valid, mask
//   cfg      sink    register index, write data
//
// A standard-format frame walks the identifiers already in the table; the single
// table comparator checks one stored entry per cycle, and a match ends the walk
// early. Remote and extended frames skip the walk and go straight to the final
// step. Reset clears the counters, the mask and the table fill count.
// A stalled result holds the next frame in its final step.
// ----------------------------------------------------------------------------
module can_frame_monitor_unit
  import cfm_pkg::*;
#(
  parameter int ID_SLOTS = 32
) (
  input  logic          clk,
  input  logic          rst,
  cfm_frame_if.sink     frame,
  cfm_result_if.source  result,
  cfm_cfg_if.sink       cfg
);

  localparam int FW = $clog2(ID_SLOTS + 1);

  ctrl_state_t    state;
  ctrl_state_t    state_next;
  frame_t         cur;
  lookup_status_t lookup;
  stats_t         stats_next;
  logic [FW-1:0]  fill;
  logic           id_added;
  logic           out_valid;
  logic           accept;
  logic           start;
  logic           commit;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (frame.is_remote || frame.is_extended) ? ST_FINISH : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (lookup.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    frame.ready = (state == ST_IDLE);
    accept      = frame.valid && (state == ST_IDLE);
    start       = accept && !frame.is_remote && !frame.is_extended;
    commit      = (state == ST_FINISH) && (!out_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur.is_remote   <= frame.is_remote;
      cur.is_extended <= frame.is_extended;
      cur.frame_id    <= frame.frame_id;
      cur.length_code <= frame.length_code;
      cur.payload_b1  <= frame.payload_b1;
      cur.payload_b2  <= frame.payload_b2;
      cur.payload_b3  <= frame.payload_b3;
      cur.payload_b4  <= frame.payload_b4;
      cur.payload_b5  <= frame.payload_b5;
      cur.payload_b6  <= frame.payload_b6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_added <= 1'b0;
    end else if (accept) begin
      id_added <= 1'b0;
    end else if (lookup.done) begin
      id_added <= lookup.added;
    end
  end

  cfm_id_table #(
    .ID_SLOTS (ID_SLOTS)
  ) u_id_table (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_key (frame.frame_id[STD_ID_W-1:0]),
    .status    (lookup),
    .fill      (fill)
  );

  assign cfg.ready = 1'b1;

  cfm_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .commit     (commit),
    .frame      (cur),
    .stats_next (stats_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.was_counted   <= stats_next.was_counted;
      result.was_reply     <= stats_next.was_reply;
      result.id_added      <= id_added;
      result.total_frames  <= stats_next.total_frames;
      result.total_replies <= stats_next.total_replies;
      result.distinct_ids  <= FILL_OUT_W'(fill);
      result.mask_valid    <= stats_next.mask_valid;
      result.pid_mask      <= stats_next.pid_mask;
    end
  end

  assign result.valid = out_valid;

endmodule

### src/cfm_checker.sv
// ----------------------------------------------------------------------------
// cfm_checker: port-level checks of the CAN frame monitor
// Watches the frame and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cfm_checker
  import cfm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             frame_valid,
  input logic             frame_ready,
  input logic             result_valid,
  input logic             result_ready,
  input logic             was_counted,
  input logic             was_reply,
  input logic             id_added,
  input logic [CNT_W-1:0] total_frames
);

  // A held result keeps its valid and its frame total.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(total_frames))
    else $error("result changed while stalled");

  // The block works on one frame at a time.
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_ready |=> !frame_ready)
    else $error("frame accepted while another is in progress");

  // A reply is always a counted frame.
  a_reply_counted: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !was_reply || was_counted)
    else $error("reply flagged on an uncounted frame");

  // Only counted frames can add to the identifier table.
  a_added_counted: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !id_added || was_counted)
    else $error("identifier added for an uncounted frame");

endmodule

bind can_frame_monitor_unit cfm_checker u_cfm_checker (
  .clk          (clk),
  .rst          (rst),
  .frame_valid  (frame.valid),
  .frame_ready  (frame.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .was_counted  (result.was_counted),
  .was_reply    (result.was_reply),
  .id_added     (result.id_added),
  .total_frames (result.total_frames)
);
